FILE: hw/rtl/priority_route_table_lookup_macros.svh
// Assertion macros used by the route table lookup RTL.
`ifndef PRIORITY_ROUTE_TABLE_LOOKUP_MACROS_SVH
`define PRIORITY_ROUTE_TABLE_LOOKUP_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define PRT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define PRT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/prt_pkg.sv
// Types, codes and defaults for the priority route table lookup.
package prt_pkg;

  // Default number of routes the table can hold.
  localparam int unsigned DEFAULT_TABLE_DEPTH = 1024;

  // Width of the reported route count.
  localparam int unsigned ENTRY_W = 11;

  // Item kinds.
  localparam logic KIND_ADD    = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  // Result status codes.
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_NOMATCH  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY    = 2'd2;
  localparam logic [1:0] STATUS_FULL     = 2'd3;

  // Request beat.
  typedef struct packed {
    logic        kind;
    logic [31:0] address;
    logic [31:0] route_mask;
    logic [31:0] hop_address;
    logic [15:0] route_priority;
  } req_t;

  // Response beat.
  typedef struct packed {
    logic [1:0]         status;
    logic [31:0]        chosen_hop;
    logic [ENTRY_W-1:0] entry_count;
  } rsp_t;

  // One stored route.
  typedef struct packed {
    logic [31:0] target;
    logic [31:0] mask;
    logic [31:0] hop;
    logic [15:0] prio;
  } route_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_LAST
  } fsm_e;

endpackage

FILE: hw/rtl/priority_route_table_lookup.sv
// Priority route table lookup: route memory, scan sequencer and shared compare unit.
//
// Usage
//   A request beat is taken on a rising edge where start is high and busy is low.
//   Its kind field selects an add (append a route) or a lookup (find the next hop
//   for a destination). Every request yields exactly one response beat on rsp_o,
//   flagged by done_o for a single cycle; the receiver cannot hold it off.
//   Timing
//   - Add: response in the cycle after acceptance; busy stays low, so an add or
//     any other request may follow in the very next cycle.
//   - Lookup on an empty table: response in the cycle after acceptance, no busy.
//   - Lookup on N routes: busy while every stored route is read and compared,
//     then the response is registered after the final compare. The single read
//     port of the route memory delivers one route per cycle to the one masked
//     compare and priority unit; no new request is taken until the scan is done.
//   Reset
//   - rst_ni clears the route count, so the table is empty after reset. The
//     route memory itself is not cleared; only written entries are ever read.
//   A new request can be accepted in the same cycle a response is shown.
module priority_route_table_lookup #(
  parameter int unsigned TABLE_DEPTH = prt_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  prt_pkg::req_t req_i,
  output logic          done_o,
  output prt_pkg::rsp_t rsp_o
);

  import prt_pkg::*;

  `include "priority_route_table_lookup_macros.svh"

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  // Sequencer and datapath registers.
  fsm_e          state_q, state_d;
  logic [AW-1:0] idx_q, idx_d;
  logic [CW-1:0] count_q, count_d;
  logic          done_q, done_d;
  rsp_t          rsp_q, rsp_d;
  logic [31:0]   dest_q, dest_d;
  logic          found_q, found_d;
  logic [31:0]   best_hop_q, best_hop_d;
  logic [15:0]   best_prio_q, best_prio_d;
  logic [31:0]   fallback_q, fallback_d;

  // Memory read pipeline.
  route_t        rd_data_q;
  logic          rd_vld_q;
  logic          rd_first_q;

  logic          accept;
  logic          table_full;
  logic          table_empty;
  logic [AW-1:0] last_idx;
  logic          mem_we;
  logic          hit;
  logic          take;

  route_t route_mem [TABLE_DEPTH];

  assign accept      = start && !busy;
  assign table_full  = (count_q == CW'(TABLE_DEPTH));
  assign table_empty = (count_q == '0);
  assign last_idx    = AW'(count_q - CW'(1));
  assign mem_we      = accept && (req_i.kind == KIND_ADD) && !table_full;

  // Route memory: appends go to the slot after the last route, scans read in order.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      route_mem[count_q[AW-1:0]] <= '{target: req_i.address, mask: req_i.route_mask,
                                      hop: req_i.hop_address, prio: req_i.route_priority};
    end
    if (state_q == S_SCAN) begin
      rd_data_q <= route_mem[idx_q];
    end
  end

  // Shared compare unit: masked match and strictly-higher priority test.
  assign hit  = ((rd_data_q.mask & rd_data_q.target) == (rd_data_q.mask & dest_q));
  assign take = rd_vld_q && hit && (!found_q || (rd_data_q.prio > best_prio_q));

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && (req_i.kind == KIND_LOOKUP) && !table_empty) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (idx_q == last_idx) begin
          state_d = S_LAST;
        end
      end
      S_LAST: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Datapath control and response build-up.
  always_comb begin
    idx_d       = idx_q;
    count_d     = count_q;
    done_d      = 1'b0;
    rsp_d       = rsp_q;
    dest_d      = dest_q;
    found_d     = found_q || take;
    best_hop_d  = take ? rd_data_q.hop : best_hop_q;
    best_prio_d = take ? rd_data_q.prio : best_prio_q;
    fallback_d  = (rd_vld_q && rd_first_q) ? rd_data_q.hop : fallback_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (req_i.kind == KIND_ADD) begin
            if (!table_full) begin
              count_d      = count_q + CW'(1);
              rsp_d.status = STATUS_OK;
            end else begin
              rsp_d.status = STATUS_FULL;
            end
            rsp_d.chosen_hop = '0;
            done_d           = 1'b1;
          end else if (table_empty) begin
            rsp_d.status     = STATUS_EMPTY;
            rsp_d.chosen_hop = '0;
            done_d           = 1'b1;
          end else begin
            dest_d  = req_i.address;
            idx_d   = '0;
            found_d = 1'b0;
          end
        end
      end
      S_SCAN: begin
        idx_d = idx_q + AW'(1);
      end
      S_LAST: begin
        // The final route is compared this cycle, so use the updated values.
        if (found_d) begin
          rsp_d.status     = STATUS_OK;
          rsp_d.chosen_hop = best_hop_d;
        end else begin
          rsp_d.status     = STATUS_NOMATCH;
          rsp_d.chosen_hop = fallback_d;
        end
        done_d = 1'b1;
      end
      default: begin
        idx_d = '0;
      end
    endcase

    rsp_d.entry_count = ENTRY_W'(count_d);
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      idx_q      <= '0;
      count_q    <= '0;
      done_q     <= 1'b0;
      found_q    <= 1'b0;
      rd_vld_q   <= 1'b0;
      rd_first_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      idx_q      <= idx_d;
      count_q    <= count_d;
      done_q     <= done_d;
      found_q    <= found_d;
      rd_vld_q   <= (state_q == S_SCAN);
      rd_first_q <= (idx_q == '0);
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    rsp_q       <= rsp_d;
    dest_q      <= dest_d;
    best_hop_q  <= best_hop_d;
    best_prio_q <= best_prio_d;
    fallback_q  <= fallback_d;
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // Checks on the sequencer.
  `PRT_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CW'(TABLE_DEPTH), "route count above depth")
  `PRT_ASSERT_NEXT(a_add_resp, accept && (req_i.kind == KIND_ADD), done_o && !busy, "add gave no response")
  `PRT_ASSERT_NEXT(a_scan_busy, accept && (req_i.kind == KIND_LOOKUP) && !table_empty, busy && !done_o, "lookup did not start a scan")
  `PRT_ASSERT_NEXT(a_last_resp, state_q == S_LAST, done_o && !busy, "scan end gave no response")

endmodule
